FILE: rtl/uclp_pkg.sv
package uclp_pkg;

  localparam int unsigned NUM_TASKS_DEF = 16;

  // Field widths of one request and one result.
  localparam int unsigned OP_W       = 2;
  localparam int unsigned TASK_W     = 4;
  localparam int unsigned SUM_W      = 44;
  localparam int unsigned TGT_W      = 32;
  localparam int unsigned CLAMP_W    = 11;
  localparam int unsigned IN_DATA_W  = 96;
  localparam int unsigned OUT_DATA_W = 32;

  // Configuration register widths.
  localparam int unsigned GAIN_W     = 10;
  localparam int unsigned UP_W       = 10;
  localparam int unsigned DOWN_W     = 7;
  localparam int unsigned WIN_W      = 9;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 11;

  // Datapath widths.
  localparam int unsigned G100_W  = 17;  // gain * 100
  localparam int unsigned PROD_W  = 61;  // |error| * gain * 100
  localparam int unsigned DVS_W   = 39;  // target * 100
  localparam int unsigned QUO2_W  = 17;  // step quotient before saturation
  localparam int unsigned STEP_W  = 18;
  localparam int unsigned NC_W    = 20;  // signed new clamp before bounding
  localparam int unsigned LOP_W   = 18;  // default * (100 - down)
  localparam int unsigned HIP_W   = 22;  // default * (100 + up)
  localparam int unsigned RECIP_W = 23;
  localparam int unsigned RPROD_W = HIP_W + RECIP_W;
  localparam int unsigned LIM_HI_W = 15;
  localparam int unsigned CNT_W   = 6;
  localparam int unsigned PC_W    = 4;

  // x / 100 == (x * RECIP_100) >> RECIP_SHIFT for every x below 6.1e6.
  localparam logic [RECIP_W-1:0] RECIP_100   = 23'd5368710;
  localparam int unsigned        RECIP_SHIFT = 29;

  localparam logic [CLAMP_W-1:0] CLAMP_MAX = 11'd1024;
  localparam logic [CLAMP_W-1:0] CLAMP_MIN = 11'd1;
  localparam logic [DOWN_W-1:0]  PCT_FULL  = 7'd100;
  localparam logic [STEP_W-1:0]  STEP_SAT  = 18'h20000;

  // Reset values of the configuration registers.
  localparam logic [CLAMP_W-1:0] FLOOR_RST   = 11'd50;
  localparam logic [CLAMP_W-1:0] DBG_MAX_RST = 11'd1000;
  localparam logic [CLAMP_W-1:0] DBG_MIN_RST = 11'd1000;
  localparam logic [WIN_W-1:0]   WINDOW_RST  = 9'd1;

  typedef enum logic [OP_W-1:0] {
    OP_FIX    = 2'd0,
    OP_SIMPLE = 2'd1,
    OP_DEBUG  = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN     = 3'd0,
    CFG_UP       = 3'd1,
    CFG_DOWN     = 3'd2,
    CFG_FLOOR    = 3'd3,
    CFG_DBG_MAX  = 3'd4,
    CFG_DBG_MIN  = 3'd5,
    CFG_WINDOW   = 3'd6
  } cfg_idx_e;

  typedef enum logic [3:0] {
    UOP_NOP,
    UOP_DIV1_INIT,
    UOP_DIV1_STEP,
    UOP_ERR,
    UOP_MUL_STEP,
    UOP_DIV2_INIT,
    UOP_DIV2_STEP,
    UOP_LIM_MUL,
    UOP_LIM_DIV,
    UOP_APPLY,
    UOP_FIX,
    UOP_DEBUG
  } uop_e;

  typedef enum logic [2:0] {
    COND_NEVER,
    COND_LOOP,
    COND_SKIP,
    COND_FIX,
    COND_DEBUG
  } cond_e;

  typedef struct packed {
    uop_e              uop;
    cond_e             cond;
    logic [PC_W-1:0]   target;
    logic              cnt_load;
    logic [CNT_W-1:0]  cnt_init;
    logic              emit;
    logic              fin;
  } ctrl_word_t;

  typedef struct packed {
    logic skip;
    logic fix;
    logic debug;
  } item_stat_t;

  typedef struct packed {
    logic [GAIN_W-1:0]  gain;
    logic [UP_W-1:0]    up_margin;
    logic [DOWN_W-1:0]  down_margin;
    logic [CLAMP_W-1:0] simple_floor;
    logic [CLAMP_W-1:0] dbg_max;
    logic [CLAMP_W-1:0] dbg_min;
    logic [WIN_W-1:0]   window;
  } cfg_t;

  localparam logic [PC_W-1:0] PC_DIV1 = 4'd4;
  localparam logic [PC_W-1:0] PC_MUL  = 4'd6;
  localparam logic [PC_W-1:0] PC_DIV2 = 4'd8;
  localparam logic [PC_W-1:0] PC_FIX  = 4'd12;
  localparam logic [PC_W-1:0] PC_DBG  = 4'd13;
  localparam logic [PC_W-1:0] PC_SKIP = 4'd14;

  // Microcode store: one control word per step.
  function automatic ctrl_word_t ucode(input logic [PC_W-1:0] pc);
    ctrl_word_t cw;
    cw = '0;
    cw.uop  = UOP_NOP;
    cw.cond = COND_NEVER;
    case (pc)
      4'd0: begin
        cw.cond   = COND_SKIP;
        cw.target = PC_SKIP;
      end
      4'd1: begin
        cw.cond   = COND_FIX;
        cw.target = PC_FIX;
      end
      4'd2: begin
        cw.cond   = COND_DEBUG;
        cw.target = PC_DBG;
      end
      4'd3: begin
        cw.uop      = UOP_DIV1_INIT;
        cw.cnt_load = 1'b1;
        cw.cnt_init = CNT_W'(SUM_W - 1);
      end
      4'd4: begin
        cw.uop    = UOP_DIV1_STEP;
        cw.cond   = COND_LOOP;
        cw.target = PC_DIV1;
      end
      4'd5: begin
        cw.uop      = UOP_ERR;
        cw.cnt_load = 1'b1;
        cw.cnt_init = CNT_W'(G100_W - 1);
      end
      4'd6: begin
        cw.uop    = UOP_MUL_STEP;
        cw.cond   = COND_LOOP;
        cw.target = PC_MUL;
      end
      4'd7: begin
        cw.uop      = UOP_DIV2_INIT;
        cw.cnt_load = 1'b1;
        cw.cnt_init = CNT_W'(QUO2_W - 1);
      end
      4'd8: begin
        cw.uop    = UOP_DIV2_STEP;
        cw.cond   = COND_LOOP;
        cw.target = PC_DIV2;
      end
      4'd9: begin
        cw.uop = UOP_LIM_MUL;
      end
      4'd10: begin
        cw.uop = UOP_LIM_DIV;
      end
      4'd11: begin
        cw.uop  = UOP_APPLY;
        cw.emit = 1'b1;
        cw.fin  = 1'b1;
      end
      4'd12: begin
        cw.uop  = UOP_FIX;
        cw.emit = 1'b1;
        cw.fin  = 1'b1;
      end
      4'd13: begin
        cw.uop  = UOP_DEBUG;
        cw.emit = 1'b1;
        cw.fin  = 1'b1;
      end
      default: begin
        cw.fin = 1'b1;
      end
    endcase
    return cw;
  endfunction

  // Limit an emitted clamp to 1..1024.
  function automatic logic [CLAMP_W-1:0] lim_out(input logic [CLAMP_W-1:0] v);
    logic [CLAMP_W-1:0] r;
    r = v;
    if (v < CLAMP_MIN) begin
      r = CLAMP_MIN;
    end else if (v > CLAMP_MAX) begin
      r = CLAMP_MAX;
    end
    return r;
  endfunction

endpackage

FILE: rtl/uclp_sequencer.sv
module uclp_sequencer (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic                   stall_i,
  input  uclp_pkg::item_stat_t   stat_i,
  output logic                   busy_o,
  output uclp_pkg::ctrl_word_t   cw_o
);

  logic                        busy_q;
  logic [uclp_pkg::PC_W-1:0]   pc_q;
  logic [uclp_pkg::CNT_W-1:0]  cnt_q;
  uclp_pkg::ctrl_word_t        cw;
  logic                        taken;

  assign cw = uclp_pkg::ucode(pc_q);

  always_comb begin
    case (cw.cond)
      uclp_pkg::COND_LOOP:  taken = (cnt_q != '0);
      uclp_pkg::COND_SKIP:  taken = stat_i.skip;
      uclp_pkg::COND_FIX:   taken = stat_i.fix;
      uclp_pkg::COND_DEBUG: taken = stat_i.debug;
      default:              taken = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pc_q   <= '0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      pc_q   <= '0;
    end else if (busy_q && !stall_i) begin
      if (cw.fin) begin
        busy_q <= 1'b0;
      end else if (taken) begin
        pc_q <= cw.target;
      end else begin
        pc_q <= pc_q + uclp_pkg::PC_W'(1);
      end
      if (cw.cnt_load) begin
        cnt_q <= cw.cnt_init;
      end else if (cw.cond == uclp_pkg::COND_LOOP) begin
        cnt_q <= cnt_q - uclp_pkg::CNT_W'(1);
      end
    end
  end

  assign busy_o = busy_q;
  assign cw_o   = cw;

endmodule

FILE: rtl/uclp_datapath.sv
module uclp_datapath #(
  parameter int unsigned NUM_TASKS = uclp_pkg::NUM_TASKS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            load_i,
  input  logic [uclp_pkg::OP_W-1:0]       op_i,
  input  logic [uclp_pkg::TASK_W-1:0]     task_index_i,
  input  logic [uclp_pkg::SUM_W-1:0]      time_sum_i,
  input  logic [uclp_pkg::TGT_W-1:0]      target_time_i,
  input  logic [uclp_pkg::CLAMP_W-1:0]    default_clamp_i,
  input  uclp_pkg::cfg_t                  cfg_i,
  input  uclp_pkg::ctrl_word_t            cw_i,
  input  logic                            exec_i,
  output uclp_pkg::item_stat_t            stat_o,
  output logic [uclp_pkg::TASK_W-1:0]     res_task_o,
  output logic [uclp_pkg::CLAMP_W-1:0]    res_max_o,
  output logic [uclp_pkg::CLAMP_W-1:0]    res_min_o
);

  localparam int unsigned IDX_W = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;

  // Captured request.
  uclp_pkg::op_e                   op_q;
  logic [uclp_pkg::TASK_W-1:0]     task_q;
  logic [uclp_pkg::SUM_W-1:0]      sum_q;   // becomes the average quotient
  logic [uclp_pkg::TGT_W-1:0]      tgt_q;
  logic [uclp_pkg::CLAMP_W-1:0]    dflt_q;

  // Working registers.
  logic [uclp_pkg::WIN_W-1:0]      rem_q;
  logic [uclp_pkg::CLAMP_W-1:0]    cur_raw_q;
  logic                            cur_vld_q;
  logic [uclp_pkg::CLAMP_W-1:0]    cur_q;
  logic                            neg_q;
  logic [uclp_pkg::SUM_W-1:0]      mcand_q;
  logic [uclp_pkg::G100_W-1:0]     mplier_q;
  logic [uclp_pkg::PROD_W-1:0]     acc_q;
  logic [uclp_pkg::DVS_W-1:0]      dvs_q;
  logic [uclp_pkg::PROD_W-1:0]     dsh_q;
  logic [uclp_pkg::QUO2_W-1:0]     quo2_q;
  logic                            sat_q;
  logic [uclp_pkg::LOP_W-1:0]      lo_prod_q;
  logic [uclp_pkg::HIP_W-1:0]      hi_prod_q;
  logic [uclp_pkg::CLAMP_W-1:0]    lo_q;
  logic [uclp_pkg::LIM_HI_W-1:0]   hi_q;

  // Latest clamp per task; valid bits stand in for the reset value of zero.
  logic [uclp_pkg::CLAMP_W-1:0]    mem_q [NUM_TASKS];
  logic [NUM_TASKS-1:0]            valid_q;

  logic [IDX_W-1:0]                idx;
  logic                            in_range;
  logic [uclp_pkg::WIN_W-1:0]      win;
  logic [uclp_pkg::WIN_W:0]        div1_t;
  logic [uclp_pkg::WIN_W:0]        div1_diff;
  logic                            div1_ge;
  logic [uclp_pkg::SUM_W-1:0]      tgt_ext;
  logic                            err_neg;
  logic [uclp_pkg::SUM_W-1:0]      err_mag;
  logic [uclp_pkg::G100_W-1:0]     g100;
  logic [uclp_pkg::DVS_W-1:0]      dvs;
  logic [uclp_pkg::PROD_W-1:0]     mul_next;
  logic [uclp_pkg::PROD_W-1:0]     sat_lim;
  logic                            div2_ge;
  logic [uclp_pkg::DOWN_W-1:0]     down_c;
  logic [uclp_pkg::RPROD_W-1:0]    lo_full;
  logic [uclp_pkg::RPROD_W-1:0]    hi_full;
  logic [uclp_pkg::STEP_W-1:0]     step_mag;
  logic signed [uclp_pkg::NC_W-1:0] cur_s, step_s, hi_s, lo_s, floor_s, top_s;
  logic signed [uclp_pkg::NC_W-1:0] nc0, nc1, nc2, nc3, nc4;
  logic [uclp_pkg::CLAMP_W-1:0]    nc_val;
  logic                            wr_en;
  logic [uclp_pkg::CLAMP_W-1:0]    wr_data;

  assign idx      = IDX_W'(task_q);
  assign in_range = (32'(task_q) < NUM_TASKS);

  assign stat_o.skip  = !in_range || (op_q == uclp_pkg::OP_NONE) ||
                        ((op_q == uclp_pkg::OP_SIMPLE) && (tgt_q == '0));
  assign stat_o.fix   = (op_q == uclp_pkg::OP_FIX);
  assign stat_o.debug = (op_q == uclp_pkg::OP_DEBUG);

  // Average: restoring division of the sum by the window, one bit a step.
  assign win       = (cfg_i.window == '0) ? uclp_pkg::WIN_W'(1) : cfg_i.window;
  assign div1_t    = {rem_q, sum_q[uclp_pkg::SUM_W-1]};
  assign div1_diff = div1_t - {1'b0, win};
  assign div1_ge   = (div1_t >= {1'b0, win});

  // Error magnitude and sign.
  assign tgt_ext = uclp_pkg::SUM_W'(tgt_q);
  assign err_neg = (sum_q < tgt_ext);
  assign err_mag = err_neg ? (tgt_ext - sum_q) : (sum_q - tgt_ext);
  assign g100    = uclp_pkg::G100_W'(cfg_i.gain) * uclp_pkg::G100_W'(uclp_pkg::PCT_FULL);
  assign dvs     = uclp_pkg::DVS_W'(tgt_q) * uclp_pkg::DVS_W'(uclp_pkg::PCT_FULL);

  // Shift-add multiply, multiplier bits taken from the top down.
  assign mul_next = {acc_q[uclp_pkg::PROD_W-2:0], 1'b0} +
                    (mplier_q[uclp_pkg::G100_W-1] ? uclp_pkg::PROD_W'(mcand_q)
                                                  : uclp_pkg::PROD_W'(0));

  // Quotients that do not fit the quotient register saturate; the bounds then win.
  assign sat_lim = uclp_pkg::PROD_W'({dvs_q, {uclp_pkg::QUO2_W{1'b0}}});
  assign div2_ge = (acc_q >= dsh_q);

  assign down_c  = (cfg_i.down_margin > uclp_pkg::PCT_FULL) ? uclp_pkg::PCT_FULL
                                                            : cfg_i.down_margin;
  assign lo_full = uclp_pkg::RPROD_W'(lo_prod_q) * uclp_pkg::RPROD_W'(uclp_pkg::RECIP_100);
  assign hi_full = uclp_pkg::RPROD_W'(hi_prod_q) * uclp_pkg::RPROD_W'(uclp_pkg::RECIP_100);

  // New clamp and its bounds, in signed arithmetic.
  assign step_mag = sat_q ? uclp_pkg::STEP_SAT : uclp_pkg::STEP_W'(quo2_q);
  assign cur_s    = $signed(uclp_pkg::NC_W'(cur_q));
  assign step_s   = $signed(uclp_pkg::NC_W'(step_mag));
  assign hi_s     = $signed(uclp_pkg::NC_W'(hi_q));
  assign lo_s     = $signed(uclp_pkg::NC_W'(lo_q));
  assign floor_s  = $signed(uclp_pkg::NC_W'(cfg_i.simple_floor));
  assign top_s    = $signed(uclp_pkg::NC_W'(uclp_pkg::CLAMP_MAX));
  assign nc0      = neg_q ? (cur_s - step_s) : (cur_s + step_s);
  assign nc1      = (nc0 > hi_s) ? hi_s : nc0;
  assign nc2      = (nc1 < lo_s) ? lo_s : nc1;
  assign nc3      = (nc2 > top_s) ? top_s : nc2;
  assign nc4      = (nc3 < floor_s) ? floor_s : nc3;
  assign nc_val   = nc4[uclp_pkg::CLAMP_W-1:0];

  always_comb begin
    case (cw_i.uop)
      uclp_pkg::UOP_FIX: begin
        wr_data   = dflt_q;
        res_max_o = uclp_pkg::lim_out(dflt_q);
        res_min_o = uclp_pkg::lim_out(dflt_q);
      end
      uclp_pkg::UOP_DEBUG: begin
        wr_data   = cfg_i.dbg_max;
        res_max_o = uclp_pkg::lim_out(cfg_i.dbg_max);
        res_min_o = uclp_pkg::lim_out(cfg_i.dbg_min);
      end
      default: begin
        wr_data   = nc_val;
        res_max_o = uclp_pkg::lim_out(nc_val);
        res_min_o = uclp_pkg::lim_out(nc_val);
      end
    endcase
  end

  assign res_task_o = task_q;
  assign wr_en      = exec_i && cw_i.emit;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[idx] <= wr_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_en) begin
      valid_q[idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      op_q   <= uclp_pkg::op_e'(op_i);
      task_q <= task_index_i;
      sum_q  <= time_sum_i;
      tgt_q  <= target_time_i;
      dflt_q <= default_clamp_i;
    end else if (exec_i) begin
      case (cw_i.uop)
        uclp_pkg::UOP_DIV1_INIT: begin
          rem_q     <= '0;
          cur_raw_q <= mem_q[idx];
          cur_vld_q <= valid_q[idx];
        end
        uclp_pkg::UOP_DIV1_STEP: begin
          rem_q <= div1_ge ? div1_diff[uclp_pkg::WIN_W-1:0]
                           : div1_t[uclp_pkg::WIN_W-1:0];
          sum_q <= {sum_q[uclp_pkg::SUM_W-2:0], div1_ge};
        end
        uclp_pkg::UOP_ERR: begin
          neg_q    <= err_neg;
          mcand_q  <= err_mag;
          mplier_q <= g100;
          acc_q    <= '0;
          dvs_q    <= dvs;
          // A stored clamp of zero falls back to the default clamp.
          cur_q    <= (cur_vld_q && (cur_raw_q != '0)) ? cur_raw_q : dflt_q;
        end
        uclp_pkg::UOP_MUL_STEP: begin
          acc_q    <= mul_next;
          mplier_q <= {mplier_q[uclp_pkg::G100_W-2:0], 1'b0};
        end
        uclp_pkg::UOP_DIV2_INIT: begin
          sat_q  <= (acc_q >= sat_lim);
          dsh_q  <= uclp_pkg::PROD_W'({dvs_q, {(uclp_pkg::QUO2_W - 1){1'b0}}});
          quo2_q <= '0;
        end
        uclp_pkg::UOP_DIV2_STEP: begin
          if (div2_ge) begin
            acc_q <= acc_q - dsh_q;
          end
          quo2_q <= {quo2_q[uclp_pkg::QUO2_W-2:0], div2_ge};
          dsh_q  <= {1'b0, dsh_q[uclp_pkg::PROD_W-1:1]};
        end
        uclp_pkg::UOP_LIM_MUL: begin
          lo_prod_q <= uclp_pkg::LOP_W'(dflt_q) *
                       uclp_pkg::LOP_W'(uclp_pkg::PCT_FULL - down_c);
          hi_prod_q <= uclp_pkg::HIP_W'(dflt_q) *
                       (uclp_pkg::HIP_W'(uclp_pkg::PCT_FULL) +
                        uclp_pkg::HIP_W'(cfg_i.up_margin));
        end
        uclp_pkg::UOP_LIM_DIV: begin
          lo_q <= lo_full[uclp_pkg::RECIP_SHIFT +: uclp_pkg::CLAMP_W];
          hi_q <= hi_full[uclp_pkg::RECIP_SHIFT +: uclp_pkg::LIM_HI_W];
        end
        default: begin
        end
      endcase
    end
  end

endmodule

FILE: rtl/uclamp_proportional_regulator_top.sv
// A request that yields no result frees the block without writing the output register.
// A new request is taken only once the sequencer is idle again. In simple mode the
// request runs through the 44-step average divider and the two 17-step multiply and
// step-divide loops of the microcoded datapath. A result waits in an output register.
// Reset clears the configuration to its defaults and every stored clamp at once.
module uclamp_proportional_regulator_top #(
  parameter int unsigned NUM_TASKS = uclp_pkg::NUM_TASKS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // op [1:0], task_index [5:2], time_sum [49:6], target_time [81:50],
  // default_clamp [92:82], zero fill [95:93]
  input  logic [uclp_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // task_out [3:0], clamp_max [14:4], clamp_min [25:15], zero fill [31:26]
  output logic [uclp_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  input  logic                                cfg_we_i,
  input  logic [uclp_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [uclp_pkg::CFG_DATA_W-1:0]     cfg_wdata_i
);

  uclp_pkg::cfg_t              cfg_q;
  uclp_pkg::ctrl_word_t        cw;
  uclp_pkg::item_stat_t        stat;
  logic                        busy;
  logic                        load;
  logic                        stall;
  logic                        exec;
  logic                        out_valid_q;
  logic [uclp_pkg::TASK_W-1:0]  res_task, out_task_q;
  logic [uclp_pkg::CLAMP_W-1:0] res_max, res_min, out_max_q, out_min_q;

  assign s_axis_tready = !busy;
  assign load          = s_axis_tvalid && s_axis_tready;
  // Only the step that hands over a result waits for the output register.
  assign stall         = cw.emit && out_valid_q && !m_axis_tready;
  assign exec          = busy && !stall;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain         <= '0;
      cfg_q.up_margin    <= '0;
      cfg_q.down_margin  <= '0;
      cfg_q.simple_floor <= uclp_pkg::FLOOR_RST;
      cfg_q.dbg_max      <= uclp_pkg::DBG_MAX_RST;
      cfg_q.dbg_min      <= uclp_pkg::DBG_MIN_RST;
      cfg_q.window       <= uclp_pkg::WINDOW_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        uclp_pkg::CFG_GAIN:    cfg_q.gain         <= cfg_wdata_i[uclp_pkg::GAIN_W-1:0];
        uclp_pkg::CFG_UP:      cfg_q.up_margin    <= cfg_wdata_i[uclp_pkg::UP_W-1:0];
        uclp_pkg::CFG_DOWN:    cfg_q.down_margin  <= cfg_wdata_i[uclp_pkg::DOWN_W-1:0];
        uclp_pkg::CFG_FLOOR:   cfg_q.simple_floor <= cfg_wdata_i;
        uclp_pkg::CFG_DBG_MAX: cfg_q.dbg_max      <= cfg_wdata_i;
        uclp_pkg::CFG_DBG_MIN: cfg_q.dbg_min      <= cfg_wdata_i;
        uclp_pkg::CFG_WINDOW:  cfg_q.window       <= cfg_wdata_i[uclp_pkg::WIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  uclp_sequencer u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (load),
    .stall_i (stall),
    .stat_i  (stat),
    .busy_o  (busy),
    .cw_o    (cw)
  );

  uclp_datapath #(
    .NUM_TASKS (NUM_TASKS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .load_i          (load),
    .op_i            (s_axis_tdata[1:0]),
    .task_index_i    (s_axis_tdata[5:2]),
    .time_sum_i      (s_axis_tdata[49:6]),
    .target_time_i   (s_axis_tdata[81:50]),
    .default_clamp_i (s_axis_tdata[92:82]),
    .cfg_i           (cfg_q),
    .cw_i            (cw),
    .exec_i          (exec),
    .stat_o          (stat),
    .res_task_o      (res_task),
    .res_max_o       (res_max),
    .res_min_o       (res_min)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (exec && cw.emit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec && cw.emit) begin
      out_task_q <= res_task;
      out_max_q  <= res_max;
      out_min_q  <= res_min;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'b0, out_min_q, out_max_q, out_task_q};

  // An accepted request sets the sequencer busy, so no request is taken in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request accepted while the sequencer should be busy");

  // A result step that is not held must leave a result in the output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy && cw.emit && !stall |=> m_axis_tvalid)
    else $error("result step completed without a result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[14:4] >= uclp_pkg::CLAMP_MIN) &&
                      (m_axis_tdata[14:4] <= uclp_pkg::CLAMP_MAX))
    else $error("clamp maximum outside 1..1024");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[25:15] >= uclp_pkg::CLAMP_MIN) &&
                      (m_axis_tdata[25:15] <= uclp_pkg::CLAMP_MAX))
    else $error("clamp minimum outside 1..1024");

endmodule

FILE: tb/uclamp_regulator_checker.sv
module uclamp_regulator_checker
  import uclp_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  req_valid_i,
  input  logic                  req_ready_i,
  // op, task_index, time_sum, target_time, default_clamp, zero fill
  input  logic [IN_DATA_W-1:0]  req_data_i,
  input  logic                  rsp_valid_i,
  input  logic                  rsp_ready_i,
  // task_out, clamp_max, clamp_min, zero fill
  input  logic [OUT_DATA_W-1:0] rsp_data_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output int                    fail_count_o,
  output int                    outstanding_o
);

  typedef struct packed {
    logic [TASK_W-1:0]  slot;
    logic [CLAMP_W-1:0] cmax;
    logic [CLAMP_W-1:0] cmin;
  } clamp_pair_t;

  clamp_pair_t        expected_clamps[$];
  logic [CLAMP_W-1:0] latest_clamp[NUM_TASKS_DEF];

  logic [GAIN_W-1:0]  gain;
  logic [UP_W-1:0]    up_margin;
  logic [DOWN_W-1:0]  down_margin;
  logic [CLAMP_W-1:0] simple_floor;
  logic [CLAMP_W-1:0] dbg_max;
  logic [CLAMP_W-1:0] dbg_min;
  logic [WIN_W-1:0]   window;

  function automatic logic [CLAMP_W-1:0] emit_limit(input logic [CLAMP_W-1:0] v);
    if (v < CLAMP_MIN) begin
      return CLAMP_MIN;
    end
    if (v > CLAMP_MAX) begin
      return CLAMP_MAX;
    end
    return v;
  endfunction

  // New clamp in simple mode. All arithmetic is 64-bit signed, so a large
  // update is carried at full precision until the bounds cut it down.
  function automatic logic [CLAMP_W-1:0] regulate_clamp(input logic [CLAMP_W-1:0] cur,
                                                        input logic [SUM_W-1:0]   sum,
                                                        input logic [TGT_W-1:0]   tgt,
                                                        input logic [CLAMP_W-1:0] dflt);
    longint win, avg, err, scaled, step, nc, down, lo, hi;
    win    = (window == 0) ? 1 : longint'(window);
    avg    = longint'(sum) / win;
    err    = avg - longint'(tgt);
    scaled = err * longint'(gain) * 100;
    step   = (scaled / longint'(tgt)) / 100;
    nc     = longint'(cur) + step;
    down   = (down_margin > 100) ? 100 : longint'(down_margin);
    lo     = (longint'(dflt) * (100 - down)) / 100;
    hi     = (longint'(dflt) * (100 + longint'(up_margin))) / 100;
    if (nc > hi) begin
      nc = hi;
    end
    if (nc < lo) begin
      nc = lo;
    end
    if (nc > 1024) begin
      nc = 1024;
    end
    if (nc < longint'(simple_floor)) begin
      nc = longint'(simple_floor);
    end
    return nc[CLAMP_W-1:0];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : track
    clamp_pair_t        want;
    clamp_pair_t        got;
    op_e                op;
    logic [TASK_W-1:0]  slot;
    logic [SUM_W-1:0]   sum;
    logic [TGT_W-1:0]   tgt;
    logic [CLAMP_W-1:0] dflt;
    logic [CLAMP_W-1:0] cur;
    if (!rst_ni) begin
      expected_clamps.delete();
      for (int i = 0; i < NUM_TASKS_DEF; i++) begin
        latest_clamp[i] = '0;
      end
      gain          = '0;
      up_margin     = '0;
      down_margin   = '0;
      simple_floor  = FLOOR_RST;
      dbg_max       = DBG_MAX_RST;
      dbg_min       = DBG_MIN_RST;
      window        = WINDOW_RST;
      fail_count_o  = 0;
      outstanding_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_GAIN:    gain         = cfg_wdata_i[GAIN_W-1:0];
          CFG_UP:      up_margin    = cfg_wdata_i[UP_W-1:0];
          CFG_DOWN:    down_margin  = cfg_wdata_i[DOWN_W-1:0];
          CFG_FLOOR:   simple_floor = cfg_wdata_i;
          CFG_DBG_MAX: dbg_max      = cfg_wdata_i;
          CFG_DBG_MIN: dbg_min      = cfg_wdata_i;
          CFG_WINDOW:  window       = cfg_wdata_i[WIN_W-1:0];
          default: ;
        endcase
      end

      if (req_valid_i && req_ready_i) begin
        op   = op_e'(req_data_i[OP_W-1:0]);
        slot = req_data_i[OP_W +: TASK_W];
        sum  = req_data_i[OP_W+TASK_W +: SUM_W];
        tgt  = req_data_i[OP_W+TASK_W+SUM_W +: TGT_W];
        dflt = req_data_i[OP_W+TASK_W+SUM_W+TGT_W +: CLAMP_W];
        want.slot = slot;
        case (op)
          OP_FIX: begin
            latest_clamp[slot] = dflt;
            want.cmax = emit_limit(dflt);
            want.cmin = emit_limit(dflt);
            expected_clamps.push_back(want);
          end
          OP_SIMPLE: begin
            // A zero target leaves the task alone and answers nothing.
            if (tgt != '0) begin
              cur = latest_clamp[slot];
              if (cur == '0) begin
                cur = dflt;
              end
              latest_clamp[slot] = regulate_clamp(cur, sum, tgt, dflt);
              want.cmax = emit_limit(latest_clamp[slot]);
              want.cmin = emit_limit(latest_clamp[slot]);
              expected_clamps.push_back(want);
            end
          end
          OP_DEBUG: begin
            latest_clamp[slot] = dbg_max;
            want.cmax = emit_limit(dbg_max);
            want.cmin = emit_limit(dbg_min);
            expected_clamps.push_back(want);
          end
          default: ;
        endcase
      end

      if (rsp_valid_i && rsp_ready_i) begin
        got.slot = rsp_data_i[0 +: TASK_W];
        got.cmax = rsp_data_i[TASK_W +: CLAMP_W];
        got.cmin = rsp_data_i[TASK_W+CLAMP_W +: CLAMP_W];
        if (expected_clamps.size() == 0) begin
          $error("unexpected result: task_out %0d, clamp_max %0d, clamp_min %0d",
                 got.slot, got.cmax, got.cmin);
          fail_count_o++;
        end else begin
          want = expected_clamps.pop_front();
          if (got.slot !== want.slot) begin
            $error("task_out mismatch: expected %0d, got %0d", want.slot, got.slot);
            fail_count_o++;
          end
          if (got.cmax !== want.cmax) begin
            $error("clamp_max mismatch: expected %0d, got %0d", want.cmax, got.cmax);
            fail_count_o++;
          end
          if (got.cmin !== want.cmin) begin
            $error("clamp_min mismatch: expected %0d, got %0d", want.cmin, got.cmin);
            fail_count_o++;
          end
        end
      end
      outstanding_o = expected_clamps.size();
    end
  end

endmodule

FILE: tb/tb_uclamp_proportional_regulator_top.sv
module tb_uclamp_proportional_regulator_top;
  import uclp_pkg::*;

  localparam int CYCLE_LIMIT    = 1000000;
  localparam int PHASES         = 8;
  localparam int PHASE_REQUESTS = 154;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;

  int fail_count;
  int outstanding;
  int cycle_count = 0;
  int burst_left = 0;
  int stim_window = 1;
  int rdy_mode = 0;
  int rdy_left = 0;

  uclamp_proportional_regulator_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  uclamp_regulator_checker clamp_monitor (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_valid_i   (s_axis_tvalid),
    .req_ready_i   (s_axis_tready),
    .req_data_i    (s_axis_tdata),
    .rsp_valid_i   (m_axis_tvalid),
    .rsp_ready_i   (m_axis_tready),
    .rsp_data_i    (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .fail_count_o  (fail_count),
    .outstanding_o (outstanding)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // The receiver switches between always ready, coin flips, long stalls and
  // mostly ready, each kept for a stretch of random length.
  always @(negedge clk_i) begin
    if (rdy_left == 0) begin
      rdy_mode <= $urandom_range(0, 3);
      rdy_left <= $urandom_range(32, 256);
    end else begin
      rdy_left <= rdy_left - 1;
    end
    case (rdy_mode)
      0:       m_axis_tready <= 1'b1;
      1:       m_axis_tready <= 1'($urandom_range(0, 1));
      2:       m_axis_tready <= ($urandom_range(0, 7) == 0);
      default: m_axis_tready <= ($urandom_range(0, 3) != 0);
    endcase
  end

  function automatic logic [IN_DATA_W-1:0] pack_request(input op_e                op,
                                                        input logic [TASK_W-1:0]  slot,
                                                        input logic [SUM_W-1:0]   sum,
                                                        input logic [TGT_W-1:0]   tgt,
                                                        input logic [CLAMP_W-1:0] dflt);
    return {{(IN_DATA_W-OP_W-TASK_W-SUM_W-TGT_W-CLAMP_W){1'b0}}, dflt, tgt, sum, slot, op};
  endfunction

  // Most requests are simple-mode updates whose average lands near the
  // target, so the stored clamps wander instead of pinning at a bound.
  function automatic logic [IN_DATA_W-1:0] random_request();
    int                 pick;
    logic [TASK_W-1:0]  slot;
    logic [TGT_W-1:0]   tgt;
    logic [CLAMP_W-1:0] dflt;
    logic [SUM_W-1:0]   noise;
    longint             win, avg, sum;
    pick  = $urandom_range(0, 99);
    slot  = TASK_W'($urandom_range(0, NUM_TASKS_DEF - 1));
    dflt  = ($urandom_range(0, 9) == 0) ? CLAMP_W'($urandom_range(0, 2047))
                                        : CLAMP_W'($urandom_range(0, 1024));
    noise = SUM_W'({$urandom(), $urandom()});
    win   = (stim_window == 0) ? longint'(1) : longint'(stim_window);
    if (pick < 4) begin
      return pack_request(op_e'($urandom_range(0, 3)), slot, noise, $urandom(),
                          CLAMP_W'($urandom_range(0, 2047)));
    end
    if (pick < 14) begin
      return pack_request(OP_FIX, slot, noise, $urandom(), dflt);
    end
    if (pick < 22) begin
      return pack_request(OP_DEBUG, slot, noise, $urandom(), dflt);
    end
    if (pick < 26) begin
      return pack_request(OP_NONE, slot, noise, $urandom(), dflt);
    end
    if (pick < 30) begin
      return pack_request(OP_SIMPLE, slot, noise, '0, dflt);
    end
    case ($urandom_range(0, 2))
      0: tgt = $urandom_range(1, 1000);
      1: tgt = $urandom_range(1, 1000000);
      default: begin
        tgt = $urandom();
        if (tgt == '0) begin
          tgt = 1;
        end
      end
    endcase
    avg = longint'(tgt) * $urandom_range(40, 160) / 100;
    sum = avg * win + $urandom_range(0, 32'(win - 1));
    return pack_request(OP_SIMPLE, slot, sum[SUM_W-1:0], tgt, dflt);
  endfunction

  task automatic send_request(input logic [IN_DATA_W-1:0] req);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        @(negedge clk_i);
        s_axis_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    burst_left--;
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= req;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // Stop sending, wait for every expected result, then let the block settle.
  task automatic wait_quiet(input int tail);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (outstanding != 0) @(negedge clk_i);
    repeat (tail) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
  endtask

  task automatic load_settings(input int g, input int up, input int dn, input int fl,
                               input int dmax, input int dmin, input int win);
    write_reg(CFG_GAIN, CFG_DATA_W'(g));
    write_reg(CFG_UP, CFG_DATA_W'(up));
    write_reg(CFG_DOWN, CFG_DATA_W'(dn));
    write_reg(CFG_FLOOR, CFG_DATA_W'(fl));
    write_reg(CFG_DBG_MAX, CFG_DATA_W'(dmax));
    write_reg(CFG_DBG_MIN, CFG_DATA_W'(dmin));
    write_reg(CFG_WINDOW, CFG_DATA_W'(win));
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    stim_window = win;
  endtask

  initial begin
    logic [IN_DATA_W-1:0] req;
    int                   counted;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: zero gain and margins pin simple mode to the default.
    send_request(pack_request(OP_SIMPLE, 4'd0, 44'd100, 32'd100, 11'd300));
    send_request(pack_request(OP_FIX, 4'd1, '0, '0, 11'd0));
    send_request(pack_request(OP_DEBUG, 4'd2, '0, '0, 11'd500));
    send_request(pack_request(OP_NONE, 4'd3, '1, '1, '1));
    send_request(pack_request(OP_SIMPLE, 4'd4, 44'd1000, '0, 11'd700));
    send_request(pack_request(OP_SIMPLE, 4'd1, 44'd5, 32'd5, 11'd0));
    send_request(pack_request(OP_FIX, 4'd5, '0, '0, 11'd2047));
    wait_quiet(20);

    // Widest gain, margins and debug maximum: down margin past 100 and a zero window.
    load_settings(1023, 1023, 127, 0, 2047, 0, 0);
    send_request(pack_request(OP_FIX, 4'd6, '0, '0, 11'd1024));
    send_request(pack_request(OP_SIMPLE, 4'd6, '1, 32'd1, 11'd1024));
    send_request(pack_request(OP_SIMPLE, 4'd6, '0, '1, 11'd1024));
    send_request(pack_request(OP_SIMPLE, 4'd7, 44'd500, 32'd1000, 11'd600));
    send_request(pack_request(OP_DEBUG, 4'd7, '0, '0, 11'd0));
    send_request(pack_request(OP_SIMPLE, 4'd7, 44'd1000, 32'd1000, 11'd2047));
    send_request(pack_request(OP_FIX, 4'd15, '1, '1, 11'd1024));
    send_request(pack_request(OP_SIMPLE, 4'd15, 44'h800_0000_0000, 32'd1, 11'd1024));
    send_request(pack_request(OP_NONE, 4'd8, '0, '0, '0));
    send_request(pack_request(OP_SIMPLE, 4'd8, 44'hAAA_AAAA_AAAA, 32'h8000_0000, 11'h555));
    wait_quiet(20);

    // A floor above 1024 is stored as is but emitted limited.
    load_settings(1023, 1023, 127, 1100, 2047, 0, 0);
    send_request(pack_request(OP_SIMPLE, 4'd9, 44'd10, 32'd10, 11'd300));
    send_request(pack_request(OP_SIMPLE, 4'd9, 44'd10, 32'd10, 11'd300));
    wait_quiet(20);

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        2:       load_settings(1023, 1023, 127, 0, 2047, 2047, 511);
        5:       load_settings(0, 0, 0, 0, 0, 0, 0);
        default: load_settings($urandom_range(0, 1000), $urandom_range(0, 900),
                               $urandom_range(0, 100), $urandom_range(0, 120),
                               $urandom_range(0, 1024), $urandom_range(0, 1024),
                               $urandom_range(0, 1) ? $urandom_range(1, 8)
                                                    : $urandom_range(1, 256));
      endcase
      counted = 0;
      while (counted < PHASE_REQUESTS) begin
        req = random_request();
        send_request(req);
        counted++;
      end
      wait_quiet(20);
    end

    wait_quiet(100);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
